// ===== rtl/pidca_pkg.sv =====
// Package for the PID controller with conditional-integration anti-windup
// Holds shared widths, saturation bounds, opcode, status and register codes
// No dependencies
package pidca_pkg;

   // default data format
   localparam int DEFAULT_DATA_WIDTH = 32;
   localparam int DEFAULT_FRAC_BITS  = 16;

   // fixed field widths
   localparam int GAIN_WIDTH     = 24;
   localparam int STEP_WIDTH     = 24;
   localparam int ACC_WIDTH      = 48;
   localparam int VAL_WIDTH      = 64;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int STATUS_WIDTH   = 2;

   // saturation bound of every multiplier product and output sum
   localparam logic [VAL_WIDTH-1:0] SAT_MAG = 64'h3FFF_FFFF_FFFF_FFFF;
   // width of a saturated magnitude
   localparam int MAG_WIDTH = 62;

   // integral bounds
   localparam logic signed [VAL_WIDTH-1:0] ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [VAL_WIDTH-1:0] ACC_MIN = -64'sh0000_8000_0000_0000;

   typedef enum logic {
      OP_STEP  = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_NORMAL  = 2'd0,
      STATUS_PRIMED  = 2'd1,
      STATUS_ZERO_DT = 2'd2,
      STATUS_CLEARED = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_LIMIT_LOW  = 3'd3,
      CSR_LIMIT_HIGH = 3'd4
   } csr_index_type;

endpackage

// ===== rtl/pidca_mul.sv =====
// Bit-serial shift-add multiplier on unsigned magnitudes
// One multiplier bit per cycle; depends on pidca_pkg
module pidca_mul #(
   parameter int XW = pidca_pkg::DEFAULT_DATA_WIDTH + 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [XW-1:0]                          a_mag,
   input  logic [pidca_pkg::GAIN_WIDTH-1:0]       b_mag,
   output logic                                   done,
   output logic [XW+pidca_pkg::GAIN_WIDTH-1:0]    product
);

   localparam int BW = pidca_pkg::GAIN_WIDTH;
   localparam int PW = XW + BW;
   localparam int CW = $clog2(BW);

   logic [PW-1:0] prod_ff, prod_in;
   logic [XW-1:0] a_ff, a_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [XW:0]   sum;

   // add the multiplicand into the upper half when the low bit is set
   always_comb begin
      sum      = {1'b0, prod_ff[PW-1:BW]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
      prod_in  = prod_ff;
      a_in     = a_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         prod_in = {{XW{1'b0}}, b_mag};
         a_in    = a_mag;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[BW-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== rtl/pidca_div.sv =====
// Bit-serial restoring divider on unsigned magnitudes
// One quotient bit per cycle; depends on pidca_pkg
module pidca_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [pidca_pkg::MAG_WIDTH-1:0]       dividend,
   input  logic [pidca_pkg::STEP_WIDTH-1:0]      divisor,
   output logic                                  done,
   output logic [pidca_pkg::MAG_WIDTH-1:0]       quotient
);

   localparam int NW = pidca_pkg::MAG_WIDTH;
   localparam int DW = pidca_pkg::STEP_WIDTH;
   localparam int CW = $clog2(NW);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dv_ff, dv_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   // shift one dividend bit into the remainder and try the subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      diff    = trial - {1'b0, dv_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dv_in   = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/pid_conditional_antiwindup_unit.sv =====
// PID step with conditional-integration anti-windup; primed, zero-step and clear
// items give their result from the decode state once the output is free. A full step
// runs seven serial multiplies (each a load, the 24-bit multiplier, a hand-off),
// a serial divide (62-bit quotient) and decode, two sums and the clamp. The next
// item is taken in the cycle after a result is loaded; a waiting result holds the
// next item in decode, or a full step in its done state.
// Synchronous reset clears gains, sets full-range limits, zeroes the integral and
// last error and arms the first-step prime. Depends on pidca_pkg, pidca_mul, pidca_div
module pid_conditional_antiwindup_unit #(
   parameter int DATA_WIDTH = pidca_pkg::DEFAULT_DATA_WIDTH,
   parameter int FRAC_BITS  = pidca_pkg::DEFAULT_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   // item in
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // error_in, time_step
   input  logic [((DATA_WIDTH+pidca_pkg::STEP_WIDTH+7)/8)*8-1:0] req_tdata,
   // opcode
   input  logic                                        req_tuser,
   // result out
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // drive
   output logic [((DATA_WIDTH+7)/8)*8-1:0]             rsp_tdata,
   // status
   output logic [pidca_pkg::STATUS_WIDTH-1:0]          rsp_tuser,
   // register writes
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [pidca_pkg::CSR_IDX_WIDTH-1:0]         csr_index,
   input  logic [((DATA_WIDTH > pidca_pkg::GAIN_WIDTH) ?
                  DATA_WIDTH : pidca_pkg::GAIN_WIDTH)-1:0] csr_data
);

   localparam int GW  = pidca_pkg::GAIN_WIDTH;
   localparam int SW  = pidca_pkg::STEP_WIDTH;
   localparam int AW  = pidca_pkg::ACC_WIDTH;
   localparam int VW  = pidca_pkg::VAL_WIDTH;
   localparam int MW  = pidca_pkg::MAG_WIDTH;
   localparam int HW  = AW - FRAC_BITS;
   localparam int XW0 = (DATA_WIDTH + 1 > HW) ? DATA_WIDTH + 1 : HW;
   localparam int XW  = (XW0 > FRAC_BITS) ? XW0 : FRAC_BITS;
   localparam int PW  = XW + GW;
   localparam int PWX = (PW > VW) ? PW : VW;
   localparam int RDW = ((DATA_WIDTH + 7) / 8) * 8;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_P, ST_IA, ST_IB, ST_DM, ST_DD, ST_Y1,
      ST_INC, ST_I2A, ST_I2B, ST_Y2, ST_DONE
   } state_type;

   // saturate a signed value to the intermediate bound
   function automatic logic signed [VW-1:0] sat_val(input logic signed [VW-1:0] x);
      logic signed [VW-1:0] r;
      r = x;
      if (x > $signed(pidca_pkg::SAT_MAG))
         r = $signed(pidca_pkg::SAT_MAG);
      else if (x < -$signed(pidca_pkg::SAT_MAG))
         r = -$signed(pidca_pkg::SAT_MAG);
      return r;
   endfunction

   state_type                   state_ff, state_in;
   logic                        go_ff, go_in;
   pidca_pkg::opcode_type       op_ff, op_in;
   logic signed [DATA_WIDTH-1:0] err_ff, err_in;
   logic [SW-1:0]               dt_ff, dt_in;
   logic signed [GW-1:0]        gp_ff, gp_in, gi_ff, gi_in, gd_ff, gd_in;
   logic signed [DATA_WIDTH-1:0] ll_ff, ll_in, lh_ff, lh_in;
   logic signed [AW-1:0]        acc_ff, acc_in;
   logic signed [DATA_WIDTH-1:0] last_ff, last_in;
   logic                        await_ff, await_in;
   logic signed [VW-1:0]        p_ff, p_in, ia_ff, ia_in, iv_ff, iv_in, dv_ff, dv_in;
   logic signed [VW-1:0]        y_ff, y_in;
   logic [MW-1:0]               dmag_ff, dmag_in;
   logic                        dneg_ff, dneg_in;
   logic                        integ_ff, integ_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] drive_ff, drive_in;
   pidca_pkg::status_type       status_ff, status_in;

   logic                        out_free;
   logic [XW-1:0]               mul_a;
   logic [GW-1:0]               mul_b;
   logic                        mul_neg;
   logic                        mul_start, mul_done;
   logic [PW-1:0]               mul_prod;
   logic [PWX-1:0]              prod_ext;
   logic [VW-1:0]               mag_sat;
   logic signed [VW-1:0]        mul_val;
   logic                        div_start, div_done;
   logic [MW-1:0]               div_quo;
   logic signed [HW-1:0]        acc_hi;
   logic signed [DATA_WIDTH:0]  err_diff;
   logic signed [VW-1:0]        y_sum, acc_sum, ll_ext, lh_ext;
   logic [GW-1:0]               gp_mag, gi_mag, gd_mag;
   logic [DATA_WIDTH-1:0]       err_mag;

   // operand magnitudes
   assign acc_hi   = acc_ff[AW-1:FRAC_BITS];
   assign err_diff = {err_ff[DATA_WIDTH-1], err_ff} - {last_ff[DATA_WIDTH-1], last_ff};
   assign gp_mag   = gp_ff[GW-1] ? GW'(-gp_ff) : GW'(gp_ff);
   assign gi_mag   = gi_ff[GW-1] ? GW'(-gi_ff) : GW'(gi_ff);
   assign gd_mag   = gd_ff[GW-1] ? GW'(-gd_ff) : GW'(gd_ff);
   assign err_mag  = err_ff[DATA_WIDTH-1] ? DATA_WIDTH'(-err_ff) : DATA_WIDTH'(err_ff);
   assign ll_ext   = VW'(ll_ff);
   assign lh_ext   = VW'(lh_ff);

   // multiplier operand select by step
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (state_ff)
         ST_P: begin
            mul_a   = XW'(err_mag);
            mul_b   = gp_mag;
            mul_neg = err_ff[DATA_WIDTH-1] ^ gp_ff[GW-1];
         end
         ST_IA, ST_I2A: begin
            mul_a   = acc_hi[HW-1] ? XW'(HW'(-acc_hi)) : XW'(HW'(acc_hi));
            mul_b   = gi_mag;
            mul_neg = acc_hi[HW-1] ^ gi_ff[GW-1];
         end
         ST_IB, ST_I2B: begin
            mul_a   = XW'(acc_ff[FRAC_BITS-1:0]);
            mul_b   = gi_mag;
            mul_neg = gi_ff[GW-1];
         end
         ST_DM: begin
            mul_a   = err_diff[DATA_WIDTH] ? XW'((DATA_WIDTH+1)'(-err_diff))
                                           : XW'((DATA_WIDTH+1)'(err_diff));
            mul_b   = gd_mag;
            mul_neg = err_diff[DATA_WIDTH] ^ gd_ff[GW-1];
         end
         ST_INC: begin
            mul_a   = XW'(err_mag);
            mul_b   = dt_ff;
            mul_neg = err_ff[DATA_WIDTH-1];
         end
         default: begin
            mul_a   = '0;
         end
      endcase
   end

   assign mul_start = go_ff && (state_ff != ST_DD);
   assign div_start = go_ff && (state_ff == ST_DD);

   pidca_mul #(.XW(XW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_mag   (mul_a),
      .b_mag   (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   pidca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dmag_ff),
      .divisor  (dt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // saturate the product magnitude and apply the sign
   assign prod_ext = PWX'(mul_prod);
   assign mag_sat  = (prod_ext > PWX'(pidca_pkg::SAT_MAG)) ? pidca_pkg::SAT_MAG
                                                           : prod_ext[VW-1:0];
   assign mul_val  = mul_neg ? -$signed(mag_sat) : $signed(mag_sat);

   assign y_sum   = sat_val(sat_val(p_ff + iv_ff) + dv_ff);
   assign acc_sum = VW'(acc_ff) + (mul_val >>> FRAC_BITS);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      op_in        = op_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      gp_in        = gp_ff;
      gi_in        = gi_ff;
      gd_in        = gd_ff;
      ll_in        = ll_ff;
      lh_in        = lh_ff;
      acc_in       = acc_ff;
      last_in      = last_ff;
      await_in     = await_ff;
      p_in         = p_ff;
      ia_in        = ia_ff;
      iv_in        = iv_ff;
      dv_in        = dv_ff;
      y_in         = y_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      integ_in     = integ_ff;
      drive_in     = drive_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // register writes
      if (csr_valid) begin
         case (pidca_pkg::csr_index_type'(csr_index))
            pidca_pkg::CSR_GAIN_P:     gp_in = csr_data[GW-1:0];
            pidca_pkg::CSR_GAIN_I:     gi_in = csr_data[GW-1:0];
            pidca_pkg::CSR_GAIN_D:     gd_in = csr_data[GW-1:0];
            pidca_pkg::CSR_LIMIT_LOW:  ll_in = csr_data[DATA_WIDTH-1:0];
            pidca_pkg::CSR_LIMIT_HIGH: lh_in = csr_data[DATA_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = pidca_pkg::opcode_type'(req_tuser);
               err_in   = req_tdata[DATA_WIDTH-1:0];
               dt_in    = req_tdata[DATA_WIDTH+SW-1:DATA_WIDTH];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (op_ff == pidca_pkg::OP_CLEAR) begin
               if (out_free) begin
                  acc_in       = '0;
                  last_in      = '0;
                  await_in     = 1'b1;
                  drive_in     = '0;
                  status_in    = pidca_pkg::STATUS_CLEARED;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (await_ff) begin
               if (out_free) begin
                  last_in      = err_ff;
                  await_in     = 1'b0;
                  drive_in     = '0;
                  status_in    = pidca_pkg::STATUS_PRIMED;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (dt_ff == '0) begin
               if (out_free) begin
                  drive_in     = '0;
                  status_in    = pidca_pkg::STATUS_ZERO_DT;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_P;
               go_in    = 1'b1;
            end
         end
         ST_P: begin
            if (mul_done) begin
               p_in     = mul_val >>> FRAC_BITS;
               state_in = ST_IA;
               go_in    = 1'b1;
            end
         end
         ST_IA, ST_I2A: begin
            if (mul_done) begin
               ia_in    = mul_val;
               state_in = (state_ff == ST_IA) ? ST_IB : ST_I2B;
               go_in    = 1'b1;
            end
         end
         ST_IB, ST_I2B: begin
            if (mul_done) begin
               iv_in    = sat_val(ia_ff + (mul_val >>> FRAC_BITS));
               state_in = (state_ff == ST_IB) ? ST_DM : ST_Y2;
               go_in    = (state_ff == ST_IB);
            end
         end
         ST_DM: begin
            if (mul_done) begin
               dmag_in  = mag_sat[MW-1:0];
               dneg_in  = mul_neg;
               state_in = ST_DD;
               go_in    = 1'b1;
            end
         end
         ST_DD: begin
            if (div_done) begin
               dv_in    = dneg_ff ? -$signed(VW'(div_quo)) : $signed(VW'(div_quo));
               state_in = ST_Y1;
            end
         end
         // skip integration when saturated in the direction the error pushes
         ST_Y1: begin
            integ_in = 1'b1;
            if (y_sum > lh_ext)
               integ_in = err_ff[DATA_WIDTH-1];
            else if (y_sum < ll_ext)
               integ_in = !err_ff[DATA_WIDTH-1] && (err_ff != '0);
            state_in = ST_INC;
            go_in    = 1'b1;
         end
         ST_INC: begin
            if (mul_done) begin
               if (integ_ff) begin
                  if (acc_sum > pidca_pkg::ACC_MAX)
                     acc_in = AW'(pidca_pkg::ACC_MAX);
                  else if (acc_sum < pidca_pkg::ACC_MIN)
                     acc_in = AW'(pidca_pkg::ACC_MIN);
                  else
                     acc_in = acc_sum[AW-1:0];
               end
               last_in  = err_ff;
               state_in = ST_I2A;
               go_in    = 1'b1;
            end
         end
         ST_Y2: begin
            y_in     = y_sum;
            state_in = ST_DONE;
         end
         // clamp to the limits, high limit first
         ST_DONE: begin
            if (out_free) begin
               if (y_ff > lh_ext)
                  drive_in = lh_ff;
               else if (y_ff < ll_ext)
                  drive_in = ll_ff;
               else
                  drive_in = y_ff[DATA_WIDTH-1:0];
               status_in    = pidca_pkg::STATUS_NORMAL;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      err_ff    <= err_in;
      dt_ff     <= dt_in;
      p_ff      <= p_in;
      ia_ff     <= ia_in;
      iv_ff     <= iv_in;
      dv_ff     <= dv_in;
      y_ff      <= y_in;
      dmag_ff   <= dmag_in;
      dneg_ff   <= dneg_in;
      integ_ff  <= integ_in;
      drive_ff  <= drive_in;
      status_ff <= status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         gp_ff        <= '0;
         gi_ff        <= '0;
         gd_ff        <= '0;
         ll_ff        <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
         lh_ff        <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
         acc_ff       <= '0;
         last_ff      <= '0;
         await_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         gp_ff        <= gp_in;
         gi_ff        <= gi_in;
         gd_ff        <= gd_in;
         ll_ff        <= ll_in;
         lh_ff        <= lh_in;
         acc_ff       <= acc_in;
         last_ff      <= last_in;
         await_ff     <= await_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RDW'($unsigned(drive_ff));
   assign rsp_tuser  = status_ff;

   // multiplier finishes only inside a multiply step
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_P || state_ff == ST_IA || state_ff == ST_IB ||
                    state_ff == ST_DM || state_ff == ST_INC || state_ff == ST_I2A ||
                    state_ff == ST_I2B))
      else $error("multiplier done outside a multiply step");

   // divider finishes only in the derivative divide step
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DD))
      else $error("divider done outside the divide step");

   // every non-normal result carries a zero drive
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != pidca_pkg::STATUS_NORMAL) |-> (drive_ff == '0))
      else $error("special result with nonzero drive");

   // a clear item re-arms the first-step prime and empties the integral
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE && op_ff == pidca_pkg::OP_CLEAR && out_free)
      |=> (await_ff && acc_ff == '0))
      else $error("clear did not reset controller state");

endmodule
